>>> hw/rtl/hds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

   localparam int unsigned TIME_W = 32;

   localparam logic [TIME_W-1:0] CHECK_LIMIT_MS = 32'd2000;
   localparam logic [TIME_W-1:0] BLOCK_HOLD_MS  = 32'd300;
   localparam logic [TIME_W-1:0] BLOCK_LIMIT_MS = 32'd4000;
   localparam logic [TIME_W-1:0] WAIT_LIMIT_MS  = 32'd6000;

   localparam logic [8:0]  RELEASE_DELAY_MS = 9'd300;
   localparam logic [8:0]  NO_DELAY_MS      = 9'd0;

   localparam logic signed [17:0] DESCENT_MARGIN_CM   = 18'sd100;
   localparam logic signed [17:0] OVERSHOOT_MARGIN_CM = 18'sd120;
   localparam logic signed [17:0] JAM_MARGIN_CM       = 18'sd150;

   localparam logic [2:0] BLOCK_MAX = 3'd3;
   localparam logic [2:0] BLOCK_SAT = 3'd7;

   localparam logic [2:0] STATUS_RUN     = 3'd0;
   localparam logic [2:0] STATUS_BOTTOM  = 3'd1;
   localparam logic [2:0] STATUS_TIMEOUT = 3'd2;
   localparam logic [2:0] STATUS_CLING   = 3'd3;
   localparam logic [2:0] STATUS_BRAKE   = 3'd4;

   localparam logic [1:0] BRAKE_NONE    = 2'd0;
   localparam logic [1:0] BRAKE_ENGAGE  = 2'd1;
   localparam logic [1:0] BRAKE_RELEASE = 2'd2;

   localparam logic [1:0] CSR_SET_HEIGHT   = 2'd0;
   localparam logic [1:0] CSR_CLUTCH_POINT = 2'd1;
   localparam logic [1:0] CSR_MIN_SPEED    = 2'd2;
   localparam logic [1:0] CSR_CLING_POWER  = 2'd3;

   localparam logic [9:0] MIN_SPEED_RESET = 10'd5;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_CHECK   = 2'd1,
      PHASE_BLOCKED = 2'd2,
      PHASE_WAIT    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [14:0]        set_height_cm;
      logic signed [15:0] clutch_point_cm;
      logic [9:0]         min_speed_cm;
      logic [15:0]        cling_power_level;
   } cfg_type;

   typedef struct packed {
      logic               operation;
      logic [31:0]        now_ms;
      logic signed [15:0] height_cm;
      logic signed [15:0] speed_cm;
      logic [15:0]        power;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       clutch_release;
      logic [1:0] brake_action;
      logic [8:0] brake_delay_ms;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/hds_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_csr
   import hds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SET_HEIGHT:   cfg_in.set_height_cm     = csr_wdata[14:0];
            CSR_CLUTCH_POINT: cfg_in.clutch_point_cm   = $signed(csr_wdata);
            CSR_MIN_SPEED:    cfg_in.min_speed_cm      = csr_wdata[9:0];
            CSR_CLING_POWER:  cfg_in.cling_power_level = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_height_cm     <= '0;
         cfg_ff.clutch_point_cm   <= '0;
         cfg_ff.min_speed_cm      <= MIN_SPEED_RESET;
         cfg_ff.cling_power_level <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hds_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_core
   import hds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      res
);

   phase_type   phase_ff, phase_in;
   logic [31:0] mark_ff, mark_in;
   logic [2:0]  count_ff, count_in;

   logic [31:0]        elapsed;
   logic signed [17:0] height_x;
   logic signed [17:0] set_x;
   logic               speed_low;
   logic               over_check, over_hold, over_block, over_wait;
   logic [2:0]         count_inc;
   logic               hold_done;

   assign elapsed    = item.now_ms - mark_ff;
   assign over_check = elapsed > CHECK_LIMIT_MS;
   assign over_hold  = elapsed > BLOCK_HOLD_MS;
   assign over_block = elapsed > BLOCK_LIMIT_MS;
   assign over_wait  = elapsed > WAIT_LIMIT_MS;
   assign height_x   = 18'(item.height_cm);
   assign set_x      = $signed({3'b000, cfg.set_height_cm});
   assign speed_low  = $signed({item.speed_cm[15], item.speed_cm})
                       < $signed({7'b0000000, cfg.min_speed_cm});
   assign count_inc  = (count_ff == BLOCK_SAT) ? count_ff : count_ff + 3'd1;
   assign hold_done  = !speed_low && over_hold;

   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      count_in = count_ff;
      res.status         = STATUS_RUN;
      res.clutch_release = 1'b0;
      res.brake_action   = BRAKE_NONE;
      res.brake_delay_ms = NO_DELAY_MS;
      if (item.operation) begin
         phase_in = PHASE_IDLE;
      end else begin
         case (phase_ff)
            PHASE_IDLE: begin
               mark_in  = item.now_ms;
               count_in = '0;
               phase_in = PHASE_CHECK;
               res.clutch_release = 1'b1;
               res.brake_action   = BRAKE_RELEASE;
               res.brake_delay_ms = RELEASE_DELAY_MS;
            end
            PHASE_CHECK: begin
               if (speed_low && height_x < set_x + DESCENT_MARGIN_CM) begin
                  phase_in = PHASE_WAIT;
                  mark_in  = item.now_ms;
               end else if (height_x > set_x + OVERSHOOT_MARGIN_CM) begin
                  res.status = STATUS_CLING;
               end else if (over_check) begin
                  phase_in = PHASE_BLOCKED;
                  mark_in  = item.now_ms;
                  count_in = count_inc;
                  res.brake_action = BRAKE_ENGAGE;
                  if (count_inc > BLOCK_MAX) begin
                     res.status = STATUS_CLING;
                  end
               end
            end
            PHASE_BLOCKED: begin
               if (speed_low || hold_done) begin
                  phase_in = PHASE_CHECK;
                  res.brake_action = BRAKE_RELEASE;
               end
               if (hold_done) begin
                  mark_in = item.now_ms;
               end
               if ((over_block && !hold_done) || height_x > set_x + JAM_MARGIN_CM) begin
                  res.status = (item.power > cfg.cling_power_level) ? STATUS_CLING
                                                                     : STATUS_BRAKE;
               end
            end
            PHASE_WAIT: begin
               if (over_wait) begin
                  res.status = STATUS_TIMEOUT;
               end else if (item.height_cm < cfg.clutch_point_cm) begin
                  res.status = STATUS_BOTTOM;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         mark_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         mark_ff  <= mark_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hammer_drop_supervisor.sv
// Hammer drop supervisor.
// Input channel req_*: one sample per transfer (operation, now_ms, height_cm,
// speed_cm, power). operation 1 restarts the sequence at idle.
// Result channel rsp_*: exactly one result per sample, in order (status,
// clutch_release, brake_action, brake_delay_ms).
// Configuration port csr_*: one register write per cycle with csr_we high.
// The user writes only while no sample is in flight, unchecked by the block.
// Path: a sample accepted from req_* lands in the input register, is evaluated
// against the drop state and reaches the result register once that register
// is free to take it.
// Throughput: one sample per cycle while rsp_ready stays high; the single pass
// of compare logic between input and result register sets this figure.
// Reset: both pipeline registers empty, phase idle, mark time and block
// count zero, registers at their reset values.
// Stall: while rsp_ready is low the result holds, the input register keeps
// one more sample, and req_ready drops only when both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module hammer_drop_supervisor
   import hds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_now_ms,
   input  wire logic signed [15:0] req_height_cm,
   input  wire logic signed [15:0] req_speed_cm,
   input  wire logic [15:0] req_power,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_clutch_release,
   output logic [1:0]       rsp_brake_action,
   output logic [8:0]       rsp_brake_delay_ms,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type cfg;
   req_type item_ff;
   rsp_type res;
   rsp_type rsp_ff;
   logic    item_valid_ff, item_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_open;
   logic    advance;
   logic    take;

   assign rsp_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && rsp_open;
   assign req_ready = !item_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign item_valid_in = take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   hds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hds_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation <= req_operation;
         item_ff.now_ms    <= req_now_ms;
         item_ff.height_cm <= req_height_cm;
         item_ff.speed_cm  <= req_speed_cm;
         item_ff.power     <= req_power;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_clutch_release = rsp_ff.clutch_release;
   assign rsp_brake_action   = rsp_ff.brake_action;
   assign rsp_brake_delay_ms = rsp_ff.brake_delay_ms;

   a_delay_only_on_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.brake_delay_ms != NO_DELAY_MS
         |-> rsp_ff.brake_action == BRAKE_RELEASE && rsp_ff.clutch_release)
      else $error("brake delay without clutch release");

   a_clutch_only_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.clutch_release |-> rsp_ff.status == STATUS_RUN)
      else $error("clutch release with error status");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("input register lost a sample");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !item_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> bench/hammer_drop_supervisor_test.sv
`timescale 1ns / 1ps

module hammer_drop_supervisor_test;
   import hds_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = 1'b0;
   logic [31:0]        req_now_ms = '0;
   logic signed [15:0] req_height_cm = '0;
   logic signed [15:0] req_speed_cm = '0;
   logic [15:0]        req_power = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic               rsp_clutch_release;
   logic [1:0]         rsp_brake_action;
   logic [8:0]         rsp_brake_delay_ms;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   cfg_type    lim;
   phase_type  drop_phase = PHASE_IDLE;
   logic [31:0] mark_ms = '0;
   logic [2:0] blocks = '0;

   rsp_type    due_replies [$];
   int         mismatches = 0;
   int         replies_checked = 0;
   int         quiet_cycles = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;

   hammer_drop_supervisor DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_now_ms         (req_now_ms),
      .req_height_cm      (req_height_cm),
      .req_speed_cm       (req_speed_cm),
      .req_power          (req_power),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_clutch_release (rsp_clutch_release),
      .rsp_brake_action   (rsp_brake_action),
      .rsp_brake_delay_ms (rsp_brake_delay_ms),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic rsp_type supervise_sample(input req_type s);
      rsp_type r;
      int      h, sp, setp, minsp, cp;
      r = '0;
      r.status = STATUS_RUN;
      r.brake_action = BRAKE_NONE;
      r.brake_delay_ms = NO_DELAY_MS;
      h = s.height_cm;
      sp = s.speed_cm;
      setp = lim.set_height_cm;
      minsp = lim.min_speed_cm;
      cp = lim.clutch_point_cm;
      if (s.operation) begin
         drop_phase = PHASE_IDLE;
      end else begin
         case (drop_phase)
            PHASE_IDLE: begin
               mark_ms = s.now_ms;
               blocks = '0;
               r.clutch_release = 1'b1;
               r.brake_action = BRAKE_RELEASE;
               r.brake_delay_ms = RELEASE_DELAY_MS;
               drop_phase = PHASE_CHECK;
            end
            PHASE_CHECK: begin
               if (sp < minsp && h < setp + DESCENT_MARGIN_CM) begin
                  drop_phase = PHASE_WAIT;
                  mark_ms = s.now_ms;
               end
               if (h > setp + OVERSHOOT_MARGIN_CM) begin
                  r.status = STATUS_CLING;
               end else if ((s.now_ms - mark_ms) > CHECK_LIMIT_MS) begin
                  drop_phase = PHASE_BLOCKED;
                  r.brake_action = BRAKE_ENGAGE;
                  mark_ms = s.now_ms;
                  if (blocks < BLOCK_SAT) blocks++;
                  if (blocks > BLOCK_MAX) r.status = STATUS_CLING;
               end
            end
            PHASE_BLOCKED: begin
               if (sp >= minsp) begin
                  if ((s.now_ms - mark_ms) > BLOCK_HOLD_MS) begin
                     drop_phase = PHASE_CHECK;
                     r.brake_action = BRAKE_RELEASE;
                     mark_ms = s.now_ms;
                  end
               end else begin
                  r.brake_action = BRAKE_RELEASE;
                  drop_phase = PHASE_CHECK;
               end
               if ((s.now_ms - mark_ms) > BLOCK_LIMIT_MS || h > setp + JAM_MARGIN_CM)
                  r.status = (s.power > lim.cling_power_level) ? STATUS_CLING : STATUS_BRAKE;
            end
            default: begin
               if (h < cp) r.status = STATUS_BOTTOM;
               if ((s.now_ms - mark_ms) > WAIT_LIMIT_MS) r.status = STATUS_TIMEOUT;
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want, got);
      $display("%0t: reply %0d, %s: expected %0d, got %0d",
               $realtime, replies_checked, what, want, got);
      mismatches++;
   endtask

   task automatic send_sample(input logic op, input logic [31:0] now,
                              input logic [15:0] height, speed, power);
      req_type s;
      s = {op, now, height, speed, power};
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= s.operation;
      req_now_ms <= s.now_ms;
      req_height_cm <= s.height_cm;
      req_speed_cm <= s.speed_cm;
      req_power <= s.power;
      do @(posedge clock); while (!req_ready);
      due_replies.push_back(supervise_sample(s));
   endtask

   task automatic await_replies;
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_limits(input logic [15:0] height_word, clutch_word,
                                 speed_word, power_word);
      logic [1:0]  regs [4];
      logic [15:0] words [4];
      regs = '{CSR_SET_HEIGHT, CSR_CLUTCH_POINT, CSR_MIN_SPEED, CSR_CLING_POWER};
      words = '{height_word, clutch_word, speed_word, power_word};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      lim.set_height_cm = height_word[14:0];
      lim.clutch_point_cm = clutch_word;
      lim.min_speed_cm = speed_word[9:0];
      lim.cling_power_level = power_word;
   endtask

   task automatic test_reset_values;
      send_sample(1'b1, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_sample(1'b0, 32'd0, 16'd0, 16'd0, 16'd0);
      send_sample(1'b0, 32'd4, 16'd0, 16'd5, 16'd0);
      send_sample(1'b0, 32'd5, 16'd0, 16'd4, 16'd0);
      send_sample(1'b0, 32'd6, 16'hFFFF, 16'd0, 16'd0);
   endtask

   task automatic test_directed_drop;
      logic [31:0] t0;
      t0 = 32'hFFFF_FF00;
      await_replies();
      program_limits(16'd1000, 16'd200, 16'd50, 16'd1000);
      send_sample(1'b1, 32'd0, 16'd0, 16'd0, 16'd0);
      send_sample(1'b0, t0, 16'd1000, 16'd0, 16'd0);
      // overshoot above the set height
      send_sample(1'b0, t0 + 10, 16'd1121, 16'd100, 16'd0);
      // no descent within the window, timestamp wraps here
      send_sample(1'b0, t0 + 2001, 16'd1000, 16'd100, 16'd0);
      send_sample(1'b0, t0 + 2100, 16'd1151, 16'd100, 16'd1001);
      send_sample(1'b0, t0 + 2302, 16'd1000, 16'd100, 16'd0);
      send_sample(1'b0, t0 + 4303, 16'd1000, 16'd100, 16'd0);
      send_sample(1'b0, t0 + 8304, 16'd1000, 16'd10, 16'd1000);
      send_sample(1'b0, t0 + 8305, 16'd1000, 16'd100, 16'd0);
      send_sample(1'b0, t0 + 8306, 16'd1000, 16'hFFFB, 16'd0);
      // fourth block in one drop
      send_sample(1'b0, t0 + 10400, 16'd1000, 16'd100, 16'd0);
      send_sample(1'b0, t0 + 10401, 16'd1000, 16'd0, 16'd0);
      send_sample(1'b0, t0 + 10402, 16'd1099, 16'd10, 16'd0);
      send_sample(1'b0, t0 + 10500, 16'd200, 16'h8000, 16'd0);
      send_sample(1'b0, t0 + 10501, 16'd199, 16'h8000, 16'd0);
      send_sample(1'b0, t0 + 16502, 16'd199, 16'h8000, 16'd0);
   endtask

   task automatic test_random_drops(input logic [15:0] height_word, clutch_word,
                                    speed_word, power_word,
                                    input int idle_pct, stall_pct, count);
      int          sent, run_len, setp, cp, minsp, cling, h, sp, pw;
      logic [31:0] stamp;
      await_replies();
      program_limits(height_word, clutch_word, speed_word, power_word);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      setp = lim.set_height_cm;
      cp = lim.clutch_point_cm;
      minsp = lim.min_speed_cm;
      cling = lim.cling_power_level;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_sample(1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                        16'($urandom), 16'($urandom));
            sent++;
         end else begin
            if ($urandom_range(0, 7) != 0) begin
               send_sample(1'b1, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
               sent++;
            end
            stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8000)
                                                : $urandom;
            run_len = $urandom_range(1, 16);
            for (int k = 0; k < run_len && sent < count; k++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: stamp += $urandom_range(0, 200);
                  4: stamp += $urandom_range(295, 305);
                  5: stamp += $urandom_range(1995, 2005);
                  6: stamp += $urandom_range(3995, 4005);
                  7: stamp += $urandom_range(5995, 6005);
                  8: stamp += $urandom_range(2000, 9000);
                  default: stamp += $urandom;
               endcase
               case ($urandom_range(0, 6))
                  0: h = setp + $urandom_range(95, 105);
                  1: h = setp + $urandom_range(115, 125);
                  2: h = setp + $urandom_range(145, 155);
                  3: h = cp + $urandom_range(0, 10) - 5;
                  4: h = setp - $urandom_range(0, 500);
                  default: h = $urandom;
               endcase
               case ($urandom_range(0, 5))
                  0, 1, 2: sp = minsp + $urandom_range(0, 6) - 3;
                  3: sp = -$urandom_range(0, 3000);
                  default: sp = $urandom;
               endcase
               pw = ($urandom_range(0, 2) != 0) ? cling + $urandom_range(0, 4) - 2 : $urandom;
               send_sample(1'b0, stamp, h[15:0], sp[15:0], pw[15:0]);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_replies
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_clutch_release, rsp_brake_action, rsp_brake_delay_ms};
         if (due_replies.size() == 0) begin
            report_mismatch("reply with nothing due, status", 0, got.status);
         end else begin
            want = due_replies.pop_front();
            if (got.status != want.status)
               report_mismatch("status", want.status, got.status);
            if (got.clutch_release != want.clutch_release)
               report_mismatch("clutch_release", want.clutch_release, got.clutch_release);
            if (got.brake_action != want.brake_action)
               report_mismatch("brake_action", want.brake_action, got.brake_action);
            if (got.brake_delay_ms != want.brake_delay_ms)
               report_mismatch("brake_delay_ms", want.brake_delay_ms, got.brake_delay_ms);
         end
         replies_checked++;
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      lim.set_height_cm = '0;
      lim.clutch_point_cm = '0;
      lim.min_speed_cm = MIN_SPEED_RESET;
      lim.cling_power_level = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_drop();
      test_random_drops(16'h8000, 16'h8000, 16'hFC00, 16'h0000, 0, 0, 160);
      test_random_drops(16'h7FFF, 16'h7FFF, 16'h03FF, 16'hFFFF, 67, 0, 160);
      test_random_drops(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 400)),
                        16'($urandom_range(0, 200)), 16'($urandom), 0, 67, 160);
      test_random_drops(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 400)),
                        16'($urandom_range(0, 200)), 16'($urandom), 6, 6, 160);
      test_random_drops(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        0, 0, 160);
      await_replies();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
